// ===== hw/rtl/ipv6eh_pkg.sv =====
package ipv6eh_pkg;

   // fixed ipv6 header geometry
   localparam int BASE_HEADER_BYTES   = 40;
   localparam int NEXT_FIELD_BASE     = 6;
   localparam int OFFSET_BITS_DEFAULT = 17;

   // protocol numbers seen in the next-header chain
   localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] NH_ROUTING    = 8'd43;
   localparam logic [7:0] NH_ESP        = 8'd50;
   localparam logic [7:0] NH_AUTH       = 8'd51;
   localparam logic [7:0] NH_DEST_OPTS  = 8'd60;
   localparam logic [7:0] NH_COMPRESS   = 8'd108;

   // one packet byte as held in the input register
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_type;

   // verdict on one next-header value
   typedef struct packed {
      logic dest_seen;
      logic done;
   } judge_type;

   // skip hop-by-hop, routing and a destination options ahead of any routing; stop on anything else
   function automatic judge_type judge_next(logic [7:0] proto, logic dest_seen);
      judge_type r;
      r.dest_seen = dest_seen;
      r.done      = 1'b0;
      case (proto)
         NH_HOP_BY_HOP: begin
            r.done = 1'b0;
         end
         NH_ROUTING: begin
            r.dest_seen = 1'b1;
         end
         NH_DEST_OPTS: begin
            if (dest_seen) begin
               r.done = 1'b1;
            end else begin
               r.dest_seen = 1'b1;
            end
         end
         NH_AUTH, NH_ESP, NH_COMPRESS: begin
            r.done = 1'b1;
         end
         default: begin
            r.done = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/ipv6_ext_header_insert_point.sv =====
// Finds where an AH, ESP or compression header goes in an IPv6 packet.
// Input channel (req_): one packet byte per transfer, from the first byte of
// the IPv6 header, with req_last_byte set on the final byte of the packet.
// Result channel (rsp_): one transfer per packet, carrying the insertion
// offset, the offset of the next-header byte to patch and a truncation flag.
// Throughput: one byte per cycle, packets back to back, unless a stalled result holds a last byte.
// The last byte sits in the input register until it can move on; the walk
// logic then loads the result register, whose valid flag drives rsp_valid.
// Reset clears both registers and puts the walk at the start of a packet;
// the walk also returns there by itself after every last byte.
// When the receiver stalls, the result holds in the result register and
// non-last bytes keep flowing; a further last byte waits in the input
// register and req_ready drops until the held result is taken.
module ipv6_ext_header_insert_point #(
   parameter int OFFSET_BITS = ipv6eh_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OFFSET_BITS-1:0] rsp_insert_offset,
   output logic [OFFSET_BITS-1:0] rsp_next_field_offset,
   output logic                   rsp_truncated
);

   ipv6eh_pkg::byte_type   req_byte;
   ipv6eh_pkg::byte_type   cur_byte;
   logic                   step;
   logic                   out_free;
   logic                   res_valid;
   logic [OFFSET_BITS-1:0] res_insert_offset;
   logic [OFFSET_BITS-1:0] res_next_field_offset;
   logic                   res_truncated;

   assign req_byte.data = req_data_byte;
   assign req_byte.last = req_last_byte;

   ipv6eh_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_byte  (req_byte),
      .out_free  (out_free),
      .step      (step),
      .cur_byte  (cur_byte)
   );

   ipv6eh_walker #(.OFFSET_BITS(OFFSET_BITS)) u_walker (
      .clock                 (clock),
      .reset                 (reset),
      .step                  (step),
      .cur_byte              (cur_byte),
      .res_valid             (res_valid),
      .res_insert_offset     (res_insert_offset),
      .res_next_field_offset (res_next_field_offset),
      .res_truncated         (res_truncated)
   );

   ipv6eh_out_stage #(.OFFSET_BITS(OFFSET_BITS)) u_out_stage (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (res_valid),
      .res_insert_offset     (res_insert_offset),
      .res_next_field_offset (res_next_field_offset),
      .res_truncated         (res_truncated),
      .out_free              (out_free),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_insert_offset     (rsp_insert_offset),
      .rsp_next_field_offset (rsp_next_field_offset),
      .rsp_truncated         (rsp_truncated)
   );

endmodule

// ===== hw/rtl/ipv6eh_in_stage.sv =====
module ipv6eh_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ipv6eh_pkg::byte_type req_byte,
   input  logic                 out_free,
   output logic                 step,
   output ipv6eh_pkg::byte_type cur_byte
);

   logic                 valid_ff;
   logic                 valid_in;
   ipv6eh_pkg::byte_type byte_ff;

   // a last byte moves on only when the result register has room
   assign step      = valid_ff && (!byte_ff.last || out_free);
   assign req_ready = !valid_ff || step;
   assign cur_byte  = byte_ff;
   assign valid_in  = (req_valid && req_ready) ? 1'b1 : (step ? 1'b0 : valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte;
      end
   end

endmodule

// ===== hw/rtl/ipv6eh_walker.sv =====
module ipv6eh_walker #(
   parameter int OFFSET_BITS = ipv6eh_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ipv6eh_pkg::byte_type   cur_byte,
   output logic                   res_valid,
   output logic [OFFSET_BITS-1:0] res_insert_offset,
   output logic [OFFSET_BITS-1:0] res_next_field_offset,
   output logic                   res_truncated
);

   localparam logic [OFFSET_BITS-1:0] OffsetMax = '1;
   localparam logic [OFFSET_BITS-1:0] BaseStart = OFFSET_BITS'(ipv6eh_pkg::BASE_HEADER_BYTES);
   localparam logic [OFFSET_BITS-1:0] FieldBase = OFFSET_BITS'(ipv6eh_pkg::NEXT_FIELD_BASE);

   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] field_ff, field_in;
   logic [7:0]             pend_ff, pend_in;
   logic                   dest_ff, dest_in;
   logic                   done_ff, done_in;

   logic                   active;
   logic [OFFSET_BITS:0]   start_plus1;
   logic [8:0]             len_units;
   logic [OFFSET_BITS:0]   hdr_sum;
   ipv6eh_pkg::judge_type  verdict;

   assign active      = (count_ff != OffsetMax) && !done_ff;
   assign start_plus1 = {1'b0, start_ff} + {{OFFSET_BITS{1'b0}}, 1'b1};
   assign len_units   = {1'b0, cur_byte.data} + 9'd1;
   assign hdr_sum     = {1'b0, start_ff} + (OFFSET_BITS + 1)'({len_units, 3'b000});

   // chain walk: next-header byte of the base header, then next and length of each skipped header
   always_comb begin
      start_in = start_ff;
      field_in = field_ff;
      pend_in  = pend_ff;
      dest_in  = dest_ff;
      done_in  = done_ff;
      verdict  = ipv6eh_pkg::judge_next(cur_byte.data, dest_ff);
      if (active) begin
         if (count_ff == FieldBase) begin
            dest_in = verdict.dest_seen;
            done_in = verdict.done;
         end else if (count_ff > FieldBase) begin
            if (count_ff == start_ff) begin
               pend_in = cur_byte.data;
            end else if ({1'b0, count_ff} == start_plus1) begin
               verdict  = ipv6eh_pkg::judge_next(pend_ff, dest_ff);
               field_in = start_ff;
               start_in = (hdr_sum > {1'b0, OffsetMax}) ? OffsetMax : hdr_sum[OFFSET_BITS-1:0];
               dest_in  = verdict.dest_seen;
               done_in  = verdict.done;
            end
         end
      end
      count_in = (count_ff != OffsetMax) ? count_ff + 1'b1 : count_ff;
   end

   // result on the last byte of a packet
   assign res_valid             = step && cur_byte.last;
   assign res_insert_offset     = start_in;
   assign res_next_field_offset = field_in;
   assign res_truncated         = !done_in &&
                                  ((count_in <= FieldBase) || (start_in == BaseStart) ||
                                   (count_in > start_in));

   // walk state, back to start of packet after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         start_ff <= BaseStart;
         field_ff <= FieldBase;
         pend_ff  <= '0;
         dest_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else if (step) begin
         if (cur_byte.last) begin
            count_ff <= '0;
            start_ff <= BaseStart;
            field_ff <= FieldBase;
            pend_ff  <= '0;
            dest_ff  <= 1'b0;
            done_ff  <= 1'b0;
         end else begin
            count_ff <= count_in;
            start_ff <= start_in;
            field_ff <= field_in;
            pend_ff  <= pend_in;
            dest_ff  <= dest_in;
            done_ff  <= done_in;
         end
      end
   end

endmodule

// ===== hw/rtl/ipv6eh_out_stage.sv =====
module ipv6eh_out_stage #(
   parameter int OFFSET_BITS = ipv6eh_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [OFFSET_BITS-1:0] res_insert_offset,
   input  logic [OFFSET_BITS-1:0] res_next_field_offset,
   input  logic                   res_truncated,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OFFSET_BITS-1:0] rsp_insert_offset,
   output logic [OFFSET_BITS-1:0] rsp_next_field_offset,
   output logic                   rsp_truncated
);

   logic                   valid_ff, valid_in;
   logic [OFFSET_BITS-1:0] insert_ff;
   logic [OFFSET_BITS-1:0] field_ff;
   logic                   trunc_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         insert_ff <= res_insert_offset;
         field_ff  <= res_next_field_offset;
         trunc_ff  <= res_truncated;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_insert_offset     = insert_ff;
   assign rsp_next_field_offset = field_ff;
   assign rsp_truncated         = trunc_ff;

endmodule

// ===== hw/rtl/ipv6eh_checker.sv =====
module ipv6eh_checker #(
   parameter int OFFSET_BITS = ipv6eh_pkg::OFFSET_BITS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [OFFSET_BITS-1:0] rsp_insert_offset,
   input logic [OFFSET_BITS-1:0] rsp_next_field_offset,
   input logic                   rsp_truncated
);

   localparam logic [OFFSET_BITS-1:0] BaseStart = OFFSET_BITS'(ipv6eh_pkg::BASE_HEADER_BYTES);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_insert_offset) && $stable(rsp_next_field_offset) &&
          $stable(rsp_truncated)))
      else $error("stalled result changed");

   // insertion never lands inside the base header
   a_insert_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_insert_offset >= BaseStart))
      else $error("insert offset below base header size");

   // the field to patch always lies before the insertion point
   a_field_before_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_next_field_offset < rsp_insert_offset))
      else $error("next-header field not before insert offset");

endmodule

bind ipv6_ext_header_insert_point ipv6eh_checker #(.OFFSET_BITS(OFFSET_BITS)) u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_insert_offset     (rsp_insert_offset),
   .rsp_next_field_offset (rsp_next_field_offset),
   .rsp_truncated         (rsp_truncated)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int OB = ipv6eh_pkg::OFFSET_BITS_DEFAULT;
   localparam int unsigned OFF_MAX = (1 << OB) - 1;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int NUM_DIR = 19;
   localparam int NUM_PHASES = 4;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_BYTES = 120;

   // one result transfer
   typedef struct packed {
      logic [OB-1:0] insert_off;
      logic [OB-1:0] field_off;
      logic          trunc;
   } insert_point_type;

   // per-packet expectation source: typed-in value or predictor
   typedef struct packed {
      logic             typed;
      insert_point_type val;
   } pkt_expect_type;

   // one directed packet: fixed header next, up to three extension headers
   typedef struct packed {
      int unsigned len;
      logic [7:0]  first_next;
      logic [2:0]  n_ext;
      logic [23:0] ext_next;
      logic [23:0] ext_len;
      logic        rep_hop;
      logic [7:0]  fill;
      logic        typed;
      logic [OB-1:0] ins;
      logic [OB-1:0] nfo;
      logic        tr;
   } pkt_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [7:0]    req_data_byte;
   logic          req_last_byte;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [OB-1:0] rsp_insert_offset;
   logic [OB-1:0] rsp_next_field_offset;
   logic          rsp_truncated;

   ipv6_ext_header_insert_point #(
      .OFFSET_BITS(OB)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_insert_offset    (rsp_insert_offset),
      .rsp_next_field_offset(rsp_next_field_offset),
      .rsp_truncated        (rsp_truncated)
   );

   // predictor state for the chain walk
   logic [OB-1:0] pv_count;
   logic [OB-1:0] pv_hdr_start;
   logic [OB-1:0] pv_field_off;
   logic [7:0]    pv_cur_next;
   logic [7:0]    pv_pending;
   logic          pv_dest_seen;
   logic          pv_done;

   insert_point_type insert_point_q[$];
   pkt_expect_type   pkt_source_q[$];

   // packet under construction
   logic [7:0]  pkt_bytes[];
   logic [7:0]  chain_next[0:7];
   logic [7:0]  chain_len[0:7];
   int          chain_cnt;
   bit          chain_rep;

   pkt_row_type dir_rows[NUM_DIR];
   int          idle_pct;
   int          stall_pct;
   int          phase_idle[NUM_PHASES];
   int          phase_stall[NUM_PHASES];
   int unsigned cycle_count;
   int          fail_count;
   int          results_checked;
   int          total_pkts;
   int unsigned total_bytes;
   int unsigned longest_pkt;
   int unsigned phase_bytes;
   int          phase_pkts;
   int          ph;
   int          r;
   int          k;
   int          hs_end;
   int          pkt_len;
   int          kind;
   pkt_expect_type src;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // walk state back to the start of a packet
   task predictor_clear();
      pv_count     = '0;
      pv_hdr_start = OB'(ipv6eh_pkg::BASE_HEADER_BYTES);
      pv_field_off = OB'(ipv6eh_pkg::NEXT_FIELD_BASE);
      pv_cur_next  = '0;
      pv_pending   = '0;
      pv_dest_seen = 1'b0;
      pv_done      = 1'b0;
   endtask

   // skip hop-by-hop, routing, a destination options ahead of any routing; stop otherwise
   task classify_next();
      if (pv_cur_next == ipv6eh_pkg::NH_HOP_BY_HOP) begin
         pv_dest_seen = pv_dest_seen;
      end else if (pv_cur_next == ipv6eh_pkg::NH_ROUTING) begin
         pv_dest_seen = 1'b1;
      end else if (pv_cur_next == ipv6eh_pkg::NH_DEST_OPTS && !pv_dest_seen) begin
         pv_dest_seen = 1'b1;
      end else begin
         pv_done = 1'b1;
      end
   endtask

   // advance the walk by one accepted byte; on the last byte queue the result
   task walk_chain_byte(input logic [7:0] b, input logic last);
      int unsigned sum;
      int unsigned len;
      insert_point_type res;
      pkt_expect_type tq;
      if (pv_count < OFF_MAX && !pv_done) begin
         if (pv_count == ipv6eh_pkg::NEXT_FIELD_BASE) begin
            pv_cur_next = b;
            classify_next();
         end else if (pv_count > ipv6eh_pkg::NEXT_FIELD_BASE) begin
            if (int'(pv_count) == int'(pv_hdr_start)) begin
               pv_pending = b;
            end else if (int'(pv_count) == int'(pv_hdr_start) + 1) begin
               sum = int'(pv_hdr_start) + ((int'(b) + 1) << 3);
               pv_field_off = pv_hdr_start;
               pv_hdr_start = (sum > OFF_MAX) ? OB'(OFF_MAX) : OB'(sum);
               pv_cur_next = pv_pending;
               classify_next();
            end
         end
      end
      if (pv_count < OFF_MAX) begin
         pv_count = pv_count + 1'b1;
      end
      if (last) begin
         len = pv_count;
         res.trunc = 1'b0;
         if (!pv_done) begin
            if (len <= ipv6eh_pkg::NEXT_FIELD_BASE) begin
               res.trunc = 1'b1;
            end else if (pv_hdr_start == ipv6eh_pkg::BASE_HEADER_BYTES) begin
               res.trunc = 1'b1;
            end else begin
               res.trunc = (len > pv_hdr_start);
            end
         end
         res.insert_off = pv_hdr_start;
         res.field_off  = pv_field_off;
         tq = pkt_source_q.pop_front();
         if (tq.typed) begin
            insert_point_q.push_back(tq.val);
         end else begin
            insert_point_q.push_back(res);
         end
         predictor_clear();
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      insert_point_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (insert_point_q.size() == 0) begin
            $error("result transfer with nothing expected: %0d %0d %0d",
                   rsp_insert_offset, rsp_next_field_offset, rsp_truncated);
            fail_count++;
         end else begin
            e = insert_point_q.pop_front();
            results_checked++;
            if (rsp_insert_offset !== e.insert_off) begin
               $error("insert_offset: expected %0d, got %0d", e.insert_off,
                      rsp_insert_offset);
               fail_count++;
            end
            if (rsp_next_field_offset !== e.field_off) begin
               $error("next_field_offset: expected %0d, got %0d", e.field_off,
                      rsp_next_field_offset);
               fail_count++;
            end
            if (rsp_truncated !== e.trunc) begin
               $error("truncated: expected %0d, got %0d", e.trunc, rsp_truncated);
               fail_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         walk_chain_byte(req_data_byte, req_last_byte);
      end
   end

   function automatic pkt_row_type pkt_row(int unsigned len, logic [7:0] first_next,
                                           logic [2:0] n_ext, logic [23:0] ext_next,
                                           logic [23:0] ext_len, logic rep_hop,
                                           logic [7:0] fill, logic typed,
                                           int unsigned ins, int unsigned nfo, logic tr);
      pkt_row_type t;
      t.len = len;
      t.first_next = first_next;
      t.n_ext = n_ext;
      t.ext_next = ext_next;
      t.ext_len = ext_len;
      t.rep_hop = rep_hop;
      t.fill = fill;
      t.typed = typed;
      t.ins = OB'(ins);
      t.nfo = OB'(nfo);
      t.tr = tr;
      return t;
   endfunction

   // protocol number for a chain entry, optionally biased toward skipped headers
   function automatic logic [7:0] pick_proto(input bit deep);
      int sel;
      if (deep && $urandom_range(0, 99) < 60) begin
         sel = $urandom_range(0, 2);
      end else begin
         sel = $urandom_range(0, 9);
      end
      case (sel)
         0: return ipv6eh_pkg::NH_HOP_BY_HOP;
         1: return ipv6eh_pkg::NH_ROUTING;
         2: return ipv6eh_pkg::NH_DEST_OPTS;
         3: return ipv6eh_pkg::NH_AUTH;
         4: return ipv6eh_pkg::NH_ESP;
         5: return ipv6eh_pkg::NH_COMPRESS;
         6: return 8'd6;
         7: return 8'd17;
         default: return 8'($urandom);
      endcase
   endfunction

   // lay out fill bytes, the fixed header next field and the chain entries
   task build_packet(input int unsigned len, input logic [7:0] first_next,
                     input bit rand_fill, input logic [7:0] fill);
      int unsigned hs;
      int i;
      logic [7:0] nx;
      logic [7:0] ln;
      pkt_bytes = new[len];
      for (int unsigned j = 0; j < len; j++) begin
         pkt_bytes[j] = rand_fill ? 8'($urandom) : fill;
      end
      if (len > ipv6eh_pkg::NEXT_FIELD_BASE) begin
         pkt_bytes[ipv6eh_pkg::NEXT_FIELD_BASE] = first_next;
      end
      hs = ipv6eh_pkg::BASE_HEADER_BYTES;
      i = 0;
      while (hs < len && (i < chain_cnt || chain_rep)) begin
         nx = (i < chain_cnt) ? chain_next[i] : ipv6eh_pkg::NH_HOP_BY_HOP;
         ln = (i < chain_cnt) ? chain_len[i] : 8'hFF;
         pkt_bytes[hs] = nx;
         if (hs + 1 < len) begin
            pkt_bytes[hs + 1] = ln;
         end
         hs = hs + ((int'(ln) + 1) << 3);
         i++;
      end
   endtask

   // one byte transfer, with random sender idle cycles first
   task send_byte(input logic [7:0] d, input logic l);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task send_packet();
      for (int unsigned j = 0; j < pkt_bytes.size(); j++) begin
         send_byte(pkt_bytes[j], j == pkt_bytes.size() - 1);
      end
      total_pkts++;
      total_bytes += pkt_bytes.size();
      if (pkt_bytes.size() > longest_pkt) begin
         longest_pkt = pkt_bytes.size();
      end
   endtask

   // random packet: mostly well-formed chains, some short and noise packets
   task make_random_packet();
      kind = $urandom_range(0, 99);
      chain_rep = 1'b0;
      chain_cnt = 0;
      if (kind < 70) begin
         chain_cnt = $urandom_range(0, 4);
         hs_end = ipv6eh_pkg::BASE_HEADER_BYTES;
         for (int i = 0; i < chain_cnt; i++) begin
            chain_next[i] = pick_proto(1'b1);
            chain_len[i] = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 3));
            hs_end += (int'(chain_len[i]) + 1) << 3;
         end
         pkt_len = hs_end + $urandom_range(0, 24) - 8;
         // long headers are cut short so the packet stays small
         if (pkt_len > 120) begin
            pkt_len = $urandom_range(41, 120);
         end
         if (pkt_len < 1) begin
            pkt_len = 1;
         end
         build_packet(pkt_len, pick_proto(1'b1), 1'b1, 8'h00);
      end else if (kind < 85) begin
         build_packet($urandom_range(1, 48), pick_proto(1'b0), 1'b1, 8'h00);
      end else begin
         build_packet($urandom_range(1, 100), 8'($urandom), 1'b1, 8'h00);
      end
      src = '0;
      pkt_source_q.push_back(src);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      rsp_ready     = 1'b0;
      idle_pct      = 0;
      stall_pct     = 0;
      fail_count    = 0;
      results_checked = 0;
      total_pkts    = 0;
      total_bytes   = 0;
      longest_pkt   = 0;
      predictor_clear();

      phase_idle[0] = 0;  phase_stall[0] = 0;
      phase_idle[1] = 66; phase_stall[1] = 0;
      phase_idle[2] = 0;  phase_stall[2] = 66;
      phase_idle[3] = 14; phase_stall[3] = 14;

      // directed packets; typed-in results only where obvious
      dir_rows[0]  = pkt_row(1, 8'h00, 0, 24'h0, 24'h0, 0, 8'h00, 1, 40, 6, 1);
      dir_rows[1]  = pkt_row(6, 8'hFF, 0, 24'h0, 24'h0, 0, 8'hFF, 1, 40, 6, 1);
      dir_rows[2]  = pkt_row(7, 8'd6, 0, 24'h0, 24'h0, 0, 8'h00, 1, 40, 6, 0);
      dir_rows[3]  = pkt_row(12, ipv6eh_pkg::NH_ESP, 0, 24'h0, 24'h0, 0, 8'h00,
                             1, 40, 6, 0);
      dir_rows[4]  = pkt_row(12, ipv6eh_pkg::NH_AUTH, 0, 24'h0, 24'h0, 0, 8'hFF,
                             1, 40, 6, 0);
      dir_rows[5]  = pkt_row(12, ipv6eh_pkg::NH_COMPRESS, 0, 24'h0, 24'h0, 0, 8'h00,
                             1, 40, 6, 0);
      dir_rows[6]  = pkt_row(12, 8'hFF, 0, 24'h0, 24'h0, 0, 8'hFF, 1, 40, 6, 0);
      dir_rows[7]  = pkt_row(41, ipv6eh_pkg::NH_HOP_BY_HOP, 0, 24'h0, 24'h0, 0, 8'h00,
                             1, 40, 6, 1);
      dir_rows[8]  = pkt_row(40, ipv6eh_pkg::NH_DEST_OPTS, 0, 24'h0, 24'h0, 0, 8'h00,
                             1, 40, 6, 1);
      dir_rows[9]  = pkt_row(7, ipv6eh_pkg::NH_HOP_BY_HOP, 0, 24'h0, 24'h0, 0, 8'h00,
                             1, 40, 6, 1);
      // chain ends right before a later header, and between its two bytes
      dir_rows[10] = pkt_row(48, ipv6eh_pkg::NH_HOP_BY_HOP, 1,
                             {16'h0, ipv6eh_pkg::NH_HOP_BY_HOP}, 24'h0,
                             0, 8'h00, 0, 0, 0, 0);
      dir_rows[11] = pkt_row(49, ipv6eh_pkg::NH_HOP_BY_HOP, 1,
                             {16'h0, ipv6eh_pkg::NH_HOP_BY_HOP}, 24'h0,
                             0, 8'h00, 0, 0, 0, 0);
      // destination options after routing, and a repeated destination options
      dir_rows[12] = pkt_row(64, ipv6eh_pkg::NH_ROUTING, 1,
                             {16'h0, ipv6eh_pkg::NH_DEST_OPTS}, 24'h1,
                             0, 8'h00, 0, 0, 0, 0);
      dir_rows[13] = pkt_row(48, ipv6eh_pkg::NH_DEST_OPTS, 1,
                             {16'h0, ipv6eh_pkg::NH_DEST_OPTS}, 24'h0,
                             0, 8'h00, 0, 0, 0, 0);
      dir_rows[14] = pkt_row(80, ipv6eh_pkg::NH_DEST_OPTS, 3,
                             {ipv6eh_pkg::NH_ESP, ipv6eh_pkg::NH_HOP_BY_HOP,
                              ipv6eh_pkg::NH_ROUTING},
                             {8'h03, 8'h00, 8'h02}, 0, 8'h00, 0, 0, 0, 0);
      // longest extension header, reaching far past the packet end
      dir_rows[15] = pkt_row(56, ipv6eh_pkg::NH_HOP_BY_HOP, 1, {16'h0, 8'd6},
                             {16'h0, 8'hFF}, 0, 8'h00, 0, 0, 0, 0);
      dir_rows[16] = pkt_row(56, ipv6eh_pkg::NH_HOP_BY_HOP, 1,
                             {16'h0, ipv6eh_pkg::NH_HOP_BY_HOP},
                             {16'h0, 8'hFF}, 0, 8'h00, 0, 0, 0, 0);
      dir_rows[17] = pkt_row(64, ipv6eh_pkg::NH_HOP_BY_HOP, 3,
                             {ipv6eh_pkg::NH_DEST_OPTS, ipv6eh_pkg::NH_DEST_OPTS,
                              ipv6eh_pkg::NH_ROUTING},
                             24'h0, 0, 8'h00, 0, 0, 0, 0);
      // chain continues into fill bytes of all ones
      dir_rows[18] = pkt_row(56, ipv6eh_pkg::NH_HOP_BY_HOP, 1,
                             {16'h0, ipv6eh_pkg::NH_HOP_BY_HOP}, 24'h0,
                             0, 8'hFF, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, no idling
      for (r = 0; r < NUM_DIR; r++) begin
         chain_cnt = dir_rows[r].n_ext;
         chain_rep = dir_rows[r].rep_hop;
         for (k = 0; k < 3; k++) begin
            chain_next[k] = dir_rows[r].ext_next[8*k +: 8];
            chain_len[k]  = dir_rows[r].ext_len[8*k +: 8];
         end
         build_packet(dir_rows[r].len, dir_rows[r].first_next, 1'b0, dir_rows[r].fill);
         src.typed = dir_rows[r].typed;
         src.val.insert_off = dir_rows[r].ins;
         src.val.field_off = dir_rows[r].nfo;
         src.val.trunc = dir_rows[r].tr;
         pkt_source_q.push_back(src);
         send_packet();
      end

      // random part over the idling phases
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         idle_pct = phase_idle[ph];
         stall_pct = phase_stall[ph];
         phase_bytes = 0;
         phase_pkts = 0;
         while (phase_bytes < PHASE_BYTES || phase_pkts < 2) begin
            make_random_packet();
            phase_bytes += pkt_bytes.size();
            phase_pkts++;
            send_packet();
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain outstanding results, then let late transfers show up
      while (insert_point_q.size() != 0 || pkt_source_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d packets, %0d bytes, longest %0d bytes, %0d results checked",
               total_pkts, total_bytes, longest_pkt, results_checked);
      $display("directed chains plus random chains under %0d idle/stall settings",
               NUM_PHASES);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
